FILE: rtl/scan_disk_scheduler_unit_macros.svh
// Assertion macros used by the checker of the disk scheduler.
`ifndef SCAN_DISK_SCHEDULER_UNIT_MACROS_SVH
`define SCAN_DISK_SCHEDULER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sds check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sds check failed in the next cycle");

`endif

FILE: rtl/sds_pkg.sv
`timescale 1ns / 1ps

package sds_pkg;

   localparam int MAX_REQUESTS  = 32;
   localparam int CYLINDER_BITS = 16;

   localparam int CYL_W      = CYLINDER_BITS;
   localparam int ADDR_W     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_W      = $clog2(MAX_REQUESTS + 1);
   localparam int FIELD_W    = 16;
   localparam int MOVE_W     = 18;
   localparam int SUM_W      = ((MOVE_W > CYL_W) ? MOVE_W : CYL_W) + 1;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [MOVE_W-1:0] MOVE_LIMIT = '1;

   localparam logic [CSR_ADDR_W-1:0] CSR_START_HEAD       = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_CYLINDER     = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_SWEEP_TOWARD_MAX = CSR_ADDR_W'(2);

   localparam logic [CSR_DATA_W-1:0] START_HEAD_RESET   = CSR_DATA_W'(0);
   localparam logic [CSR_DATA_W-1:0] MAX_CYLINDER_RESET = CSR_DATA_W'(199);
   localparam logic                  SWEEP_RESET        = 1'b1;

   typedef logic [CYL_W-1:0] cyl_type;

   typedef struct packed {
      cyl_type start_head;
      cyl_type max_cylinder;
      logic    sweep_toward_max;
   } cfg_type;

   typedef struct packed {
      logic [FIELD_W-1:0] position;
      logic [MOVE_W-1:0]  running_movement;
      logic               is_turn_point;
      logic               last_result;
   } result_type;

   typedef struct packed {
      logic    a_gt_b;
      cyl_type distance;
   } alu_out_type;

endpackage

FILE: rtl/sds_if.sv
`timescale 1ns / 1ps

interface sds_req_if;
   import sds_pkg::*;
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] request_cylinder;
   logic               last_request;
   modport source (output valid, request_cylinder, last_request, input ready);
   modport sink (input valid, request_cylinder, last_request, output ready);
endinterface

interface sds_rsp_if;
   import sds_pkg::*;
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] position;
   logic [MOVE_W-1:0]  running_movement;
   logic               is_turn_point;
   logic               last_result;
   modport source (output valid, position, running_movement, is_turn_point, last_result,
                   input ready);
   modport sink (input valid, position, running_movement, is_turn_point, last_result,
                 output ready);
endinterface

FILE: rtl/sds_alu.sv
`timescale 1ns / 1ps

module sds_alu (
   input  sds_pkg::cyl_type     op_a,
   input  sds_pkg::cyl_type     op_b,
   output sds_pkg::alu_out_type result
);
   import sds_pkg::*;

   logic [CYL_W:0] diff;
   logic [CYL_W:0] neg;

   // The one difference op_a - op_b yields both the ordering and, negated when below zero, the absolute distance.
   always_comb begin
      diff            = {1'b0, op_a} - {1'b0, op_b};
      neg             = '0 - diff;
      result.a_gt_b   = !diff[CYL_W] && (diff != '0);
      result.distance = diff[CYL_W] ? neg[CYL_W-1:0] : diff[CYL_W-1:0];
   end

endmodule

FILE: rtl/sds_ctrl.sv
`timescale 1ns / 1ps

module sds_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sds_pkg::cyl_type    req_cylinder,
   input  logic                req_last,
   input  sds_pkg::cfg_type    cfg,
   input  logic                out_free,
   output logic                res_valid,
   output sds_pkg::result_type res
);
   import sds_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SORT_START, S_SORT_RDI, S_SORT_GETV, S_SORT_CMP, S_SORT_PUT,
      S_CNT_RD, S_CNT_CMP, S_EMIT_SEL, S_EMIT_LOAD, S_EMIT_OUT
   } state_type;

   typedef enum logic [1:0] {G_FIRST, G_TURN, G_SECOND} group_type;

   state_type          state_ff, state_in;
   group_type          group_ff, group_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   lower_ff, lower_in;
   logic [CNT_W-1:0]   emit_ff, emit_in;
   cyl_type            v_ff, v_in;
   cyl_type            target_ff, target_in;
   cyl_type            head_ff, head_in;
   logic [MOVE_W-1:0]  total_ff, total_in;
   logic               turn_ff, turn_in;

   cyl_type            mem [MAX_REQUESTS];
   cyl_type            rdata_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ADDR_W-1:0]  mem_raddr;
   cyl_type            mem_wdata;

   cyl_type            alu_a;
   cyl_type            alu_b;
   alu_out_type        alu_res;

   logic [CNT_W-1:0]   im1, ip1, jm1, jm2, ptrm1;
   logic [SUM_W-1:0]   sum;
   logic [MOVE_W-1:0]  total_sat;
   logic               is_last;
   logic               up_group;

   sds_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu_res)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      im1       = i_ff - CNT_W'(1);
      ip1       = i_ff + CNT_W'(1);
      jm1       = j_ff - CNT_W'(1);
      jm2       = j_ff - CNT_W'(2);
      ptrm1     = ptr_ff - CNT_W'(1);
      is_last   = (emit_ff == count_ff);
      up_group  = (cfg.sweep_toward_max && (group_ff == G_FIRST)) ||
                  (!cfg.sweep_toward_max && (group_ff == G_SECOND));

      state_in  = state_ff;
      group_in  = group_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      ptr_in    = ptr_ff;
      lower_in  = lower_ff;
      emit_in   = emit_ff;
      v_in      = v_ff;
      target_in = target_ff;
      head_in   = head_ff;
      total_in  = total_ff;
      turn_in   = turn_ff;
      mem_we    = 1'b0;
      mem_waddr = count_ff[ADDR_W-1:0];
      mem_wdata = req_cylinder;
      mem_raddr = ptr_ff[ADDR_W-1:0];
      alu_a     = target_ff;
      alu_b     = head_ff;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_REQUESTS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  state_in = S_SORT_START;
               end
            end
         end
         S_SORT_START: begin
            i_in     = CNT_W'(1);
            ptr_in   = '0;
            lower_in = '0;
            state_in = (count_ff > CNT_W'(1)) ? S_SORT_RDI : S_CNT_RD;
         end
         S_SORT_RDI: begin
            mem_raddr = i_ff[ADDR_W-1:0];
            state_in  = S_SORT_GETV;
         end
         S_SORT_GETV: begin
            v_in      = rdata_ff;
            j_in      = i_ff;
            mem_raddr = im1[ADDR_W-1:0];
            state_in  = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            alu_a     = rdata_ff;
            alu_b     = v_ff;
            mem_we    = 1'b1;
            mem_waddr = j_ff[ADDR_W-1:0];
            if (alu_res.a_gt_b) begin
               mem_wdata = rdata_ff;
               j_in      = jm1;
               if (jm1 != '0) begin
                  mem_raddr = jm2[ADDR_W-1:0];
               end else begin
                  state_in = S_SORT_PUT;
               end
            end else begin
               mem_wdata = v_ff;
               i_in      = ip1;
               state_in  = (ip1 < count_ff) ? S_SORT_RDI : S_CNT_RD;
            end
         end
         S_SORT_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[ADDR_W-1:0];
            mem_wdata = v_ff;
            i_in      = ip1;
            state_in  = (ip1 < count_ff) ? S_SORT_RDI : S_CNT_RD;
         end
         S_CNT_RD: begin
            if (ptr_ff < count_ff) begin
               mem_raddr = ptr_ff[ADDR_W-1:0];
               state_in  = S_CNT_CMP;
            end else begin
               ptr_in   = lower_ff;
               group_in = G_FIRST;
               emit_in  = '0;
               head_in  = cfg.start_head;
               total_in = '0;
               state_in = S_EMIT_SEL;
            end
         end
         S_CNT_CMP: begin
            alu_a  = cfg.start_head;
            alu_b  = rdata_ff;
            ptr_in = ptr_ff + CNT_W'(1);
            if (alu_res.a_gt_b) begin
               lower_in = lower_ff + CNT_W'(1);
            end
            state_in = S_CNT_RD;
         end
         S_EMIT_SEL: begin
            if (group_ff == G_TURN) begin
               target_in = cfg.sweep_toward_max ? cfg.max_cylinder : '0;
               turn_in   = 1'b1;
               group_in  = G_SECOND;
               ptr_in    = lower_ff;
               state_in  = S_EMIT_OUT;
            end else if (up_group && (ptr_ff < count_ff)) begin
               mem_raddr = ptr_ff[ADDR_W-1:0];
               ptr_in    = ptr_ff + CNT_W'(1);
               state_in  = S_EMIT_LOAD;
            end else if (!up_group && (ptr_ff != '0)) begin
               mem_raddr = ptrm1[ADDR_W-1:0];
               ptr_in    = ptrm1;
               state_in  = S_EMIT_LOAD;
            end else if (group_ff == G_FIRST) begin
               group_in = G_TURN;
            end else begin
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         S_EMIT_LOAD: begin
            target_in = rdata_ff;
            turn_in   = 1'b0;
            state_in  = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (out_free) begin
               res_valid = 1'b1;
               head_in   = target_ff;
               total_in  = total_sat;
               emit_in   = emit_ff + CNT_W'(1);
               if (is_last) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EMIT_SEL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      sum                  = SUM_W'(total_ff) + SUM_W'(alu_res.distance);
      total_sat            = (sum > SUM_W'(MOVE_LIMIT)) ? MOVE_LIMIT : sum[MOVE_W-1:0];
      res.position         = FIELD_W'(target_ff);
      res.running_movement = total_sat;
      res.is_turn_point    = turn_ff;
      res.last_result      = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         group_ff <= G_FIRST;
         count_ff <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         ptr_ff   <= '0;
         lower_ff <= '0;
         emit_ff  <= '0;
         head_ff  <= '0;
         total_ff <= '0;
         turn_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         group_ff <= group_in;
         count_ff <= count_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         ptr_ff   <= ptr_in;
         lower_ff <= lower_in;
         emit_ff  <= emit_in;
         head_ff  <= head_in;
         total_ff <= total_in;
         turn_ff  <= turn_in;
      end
      v_ff      <= v_in;
      target_ff <= target_in;
   end

endmodule

FILE: rtl/scan_disk_scheduler_unit.sv
`timescale 1ns / 1ps
// SCAN disk scheduler. Cylinder requests arrive on req_chan, one per transfer,
// and the transfer with last_request set closes the batch. Each batch request
// is taken in the cycle it is offered while req_chan.ready is high. After the
// closing transfer ready stays low while the batch is sorted in place in a local
// two-port memory and the service order is sent on rsp_chan, one transfer per
// head move, the last one flagged with last_result. A batch of n stored
// requests gives n + 1 results; requests past MAX_REQUESTS are dropped. Sorting
// by insertion, counting the requests below the start head and reading each
// result all use the registered memory read and the single shared compare and
// distance unit. Results pass through one output register, so a stalled
// receiver holds the sequencer at its next result and nothing is lost. The
// csr_ port writes start_head, max_cylinder and sweep_toward_max by index and
// must only be used while no batch is in flight. Synchronous reset empties the
// request store, restores the register defaults (start 0, maximum 199, sweep
// toward maximum) and drops a pending result.

module scan_disk_scheduler_unit (
   input  logic                             clock,
   input  logic                             reset,
   sds_req_if.sink                          req_chan,
   sds_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [sds_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [sds_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import sds_pkg::*;

   logic [CSR_DATA_W-1:0] start_head_ff, start_head_in;
   logic [CSR_DATA_W-1:0] max_cyl_ff, max_cyl_in;
   logic                  sweep_ff, sweep_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff, rsp_data_in;
   cfg_type               cfg;
   logic                  out_free;
   logic                  res_valid;
   result_type            res;

   always_comb begin
      start_head_in = start_head_ff;
      max_cyl_in    = max_cyl_ff;
      sweep_in      = sweep_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_HEAD:       start_head_in = csr_write_data;
            CSR_MAX_CYLINDER:     max_cyl_in    = csr_write_data;
            CSR_SWEEP_TOWARD_MAX: sweep_in      = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.start_head       = CYL_W'(start_head_ff);
      cfg.max_cylinder     = CYL_W'(max_cyl_ff);
      cfg.sweep_toward_max = sweep_ff;
      out_free             = !rsp_valid_ff || rsp_chan.ready;
      rsp_valid_in         = rsp_valid_ff;
      rsp_data_in          = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff <= START_HEAD_RESET;
         max_cyl_ff    <= MAX_CYLINDER_RESET;
         sweep_ff      <= SWEEP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_head_ff <= start_head_in;
         max_cyl_ff    <= max_cyl_in;
         sweep_ff      <= sweep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   sds_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_cylinder (CYL_W'(req_chan.request_cylinder)),
      .req_last     (req_chan.last_request),
      .cfg          (cfg),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res)
   );

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.position         = rsp_data_ff.position;
   assign rsp_chan.running_movement = rsp_data_ff.running_movement;
   assign rsp_chan.is_turn_point    = rsp_data_ff.is_turn_point;
   assign rsp_chan.last_result      = rsp_data_ff.last_result;

endmodule

FILE: rtl/sds_checker.sv
`timescale 1ns / 1ps
`include "scan_disk_scheduler_unit_macros.svh"

module sds_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);

   `SDS_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SDS_ASSERT_NEXT(a_last_stops_intake, clock, reset, req_valid && req_ready && req_last, !req_ready)
   `SDS_ASSERT_NEXT(a_plain_keeps_ready, clock, reset, req_valid && req_ready && !req_last, req_ready)
   `SDS_ASSERT_SAME(a_idle_pending_is_last, clock, reset, rsp_valid && req_ready, rsp_last)
   `SDS_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind scan_disk_scheduler_unit sds_checker u_sds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_request),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last_result)
);

FILE: test/tb_scan_disk_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_scan_disk_scheduler_unit;
   import sds_pkg::*;

   localparam int RANDOM_ITEMS = 195;
   localparam int QUIET_AFTER  = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 16;
   localparam int DRAIN_LIMIT  = 100000;

   class service_order_board;
      cyl_type    start_reg;
      cyl_type    max_reg;
      logic       toward_max_reg;
      cyl_type    batch[$];
      result_type pending_moves[$];
      cyl_type    head_pos;
      logic [MOVE_W-1:0] travel;
      int errors;
      int results_checked;
      int batches_closed;
      int requests_taken;
      int requests_dropped;
      int settings_used;

      function new();
         start_reg      = START_HEAD_RESET;
         max_reg        = MAX_CYLINDER_RESET;
         toward_max_reg = SWEEP_RESET;
         head_pos       = '0;
         travel         = '0;
         settings_used  = 1;
      endfunction

      function void configure(cyl_type head, cyl_type top, logic toward_max);
         start_reg      = head;
         max_reg        = top;
         toward_max_reg = toward_max;
         settings_used++;
      endfunction

      function result_type step_to(cyl_type target, logic turn);
         result_type       move;
         longint unsigned  sum;
         sum = longint'(travel) + ((target > head_pos) ? longint'(target) - longint'(head_pos)
                                                       : longint'(head_pos) - longint'(target));
         travel   = (sum > longint'(MOVE_LIMIT)) ? MOVE_LIMIT : sum[MOVE_W-1:0];
         head_pos = target;
         move.position         = target;
         move.running_movement = travel;
         move.is_turn_point    = turn;
         move.last_result      = 1'b0;
         return move;
      endfunction

      // A request is stored unless the store is full; the closing request
      // turns the stored batch into its SCAN service order.
      function void note_request(cyl_type cylinder, logic closes_batch);
         cyl_type    ordered[$];
         result_type moves[$];
         result_type tail;
         int         below;
         requests_taken++;
         if (batch.size() < MAX_REQUESTS) batch.push_back(cylinder);
         else requests_dropped++;
         if (!closes_batch) return;
         ordered = batch;
         ordered.sort();
         head_pos = start_reg;
         travel   = '0;
         below    = 0;
         foreach (ordered[i]) if (ordered[i] < start_reg) below++;
         if (!toward_max_reg) begin
            for (int i = below - 1; i >= 0; i--) moves.push_back(step_to(ordered[i], 1'b0));
            moves.push_back(step_to('0, 1'b1));
            for (int i = below; i < ordered.size(); i++)
               moves.push_back(step_to(ordered[i], 1'b0));
         end else begin
            for (int i = below; i < ordered.size(); i++)
               moves.push_back(step_to(ordered[i], 1'b0));
            moves.push_back(step_to(max_reg, 1'b1));
            for (int i = below - 1; i >= 0; i--) moves.push_back(step_to(ordered[i], 1'b0));
         end
         tail = moves.pop_back();
         tail.last_result = 1'b1;
         moves.push_back(tail);
         foreach (moves[i]) pending_moves.push_back(moves[i]);
         batch.delete();
         batches_closed++;
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_moves.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, actual %p", $time, got);
            return;
         end
         want = pending_moves.pop_front();
         results_checked++;
         if (got.position !== want.position) begin
            errors++;
            $display("%0t: position expected %0d actual %0d",
                     $time, want.position, got.position);
         end
         if (got.running_movement !== want.running_movement) begin
            errors++;
            $display("%0t: running_movement expected %0d actual %0d",
                     $time, want.running_movement, got.running_movement);
         end
         if (got.is_turn_point !== want.is_turn_point) begin
            errors++;
            $display("%0t: is_turn_point expected %0b actual %0b",
                     $time, want.is_turn_point, got.is_turn_point);
         end
         if (got.last_result !== want.last_result) begin
            errors++;
            $display("%0t: last_result expected %0b actual %0b",
                     $time, want.last_result, got.last_result);
         end
      endfunction

      function int pending();
         return pending_moves.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   logic gaps_on     = 1'b1;
   logic stalls_on   = 1'b1;
   logic hold_output = 1'b0;

   service_order_board schedule = new();

   sds_req_if req_chan ();
   sds_rsp_if rsp_chan ();

   scan_disk_scheduler_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      result_type seen;
      seen = {rsp_chan.position, rsp_chan.running_movement, rsp_chan.is_turn_point,
              rsp_chan.last_result};
      if (!reset && rsp_chan.valid && rsp_chan.ready) schedule.check_result(seen);
   end

   // Receiver: random stalls, one long hold on request, steady acceptance at the end.
   initial begin
      int span;
      forever begin
         if (hold_output) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_output = 1'b0;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            span = stalls_on ? $urandom_range(1, 20) : 1;
            repeat (span) @(posedge clock);
         end
      end
   end

   task automatic send_request(input cyl_type cylinder, input logic closes_batch);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.request_cylinder <= cylinder;
      req_chan.last_request     <= closes_batch;
      do @(posedge clock); while (!req_chan.ready);
      schedule.note_request(cylinder, closes_batch);
   endtask

   task automatic send_batch(input cyl_type cylinders[$]);
      foreach (cylinders[i]) send_request(cylinders[i], i == cylinders.size() - 1);
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      while (schedule.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_scheduler(input cyl_type head, input cyl_type top,
                                    input logic toward_max);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_START_HEAD;
      csr_write_data   <= head;
      @(posedge clock);
      csr_index        <= CSR_MAX_CYLINDER;
      csr_write_data   <= top;
      @(posedge clock);
      csr_index        <= CSR_SWEEP_TOWARD_MAX;
      csr_write_data   <= CSR_DATA_W'(toward_max);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      schedule.configure(head, top, toward_max);
   endtask

   function automatic cyl_type pick_register_value();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return cyl_type'($urandom_range(0, 255));
         default: return cyl_type'($urandom());
      endcase
   endfunction

   // Requests cluster around the start head and the end cylinders so that
   // both groups, duplicates and requests beyond the maximum all occur.
   function automatic cyl_type pick_cylinder(cyl_type head, cyl_type top);
      case ($urandom_range(0, 5))
         0, 1: return cyl_type'($urandom());
         2: return cyl_type'(int'(head) + $urandom_range(0, 40) - 20);
         3: return cyl_type'(int'(top) + $urandom_range(0, 40) - 20);
         4: return $urandom_range(0, 1) ? cyl_type'('1) : cyl_type'('0);
         default: return $urandom_range(0, 1) ? head : top;
      endcase
   endfunction

   initial begin
      cyl_type head;
      cyl_type top;
      cyl_type cylinders[$];
      int      random_items;
      int      phase;
      int      size;
      reset                     <= 1'b1;
      req_chan.valid            <= 1'b0;
      req_chan.request_cylinder <= '0;
      req_chan.last_request     <= 1'b0;
      csr_write_enable          <= 1'b0;
      csr_index                 <= CSR_START_HEAD;
      csr_write_data            <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default settings: a lone request at zero, then one far above the maximum.
      send_batch('{16'd0});
      send_batch('{16'hFFFF});
      drain_results();
      program_scheduler(16'd100, 16'hFFFF, 1'b0);
      send_batch('{16'd50, 16'd150, 16'd100, 16'd0, 16'hFFFF});
      drain_results();
      // Largest head travel the cylinder range allows.
      program_scheduler(16'hFFFF, 16'd0, 1'b1);
      send_batch('{16'hFFFF, 16'hFFFE, 16'd0});
      drain_results();
      program_scheduler(16'd1000, 16'd2000, 1'b1);
      send_batch('{16'd500});
      send_batch('{16'd3000, 16'd1500});
      drain_results();
      program_scheduler(16'd0, 16'hFFFF, 1'b0);
      send_batch('{16'd7, 16'd7});
      drain_results();

      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= QUIET_AFTER) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         head = pick_register_value();
         top  = ($urandom_range(0, 4) == 0) ? cyl_type'(199) : pick_register_value();
         program_scheduler(head, top, 1'($urandom_range(0, 1)));
         if (phase == 1) hold_output = 1'b1;
         repeat ($urandom_range(1, 4)) begin
            size = ($urandom_range(0, 7) == 0 && phase != 1)
                   ? $urandom_range(MAX_REQUESTS, MAX_REQUESTS + 3) : $urandom_range(1, 10);
            cylinders.delete();
            repeat (size) cylinders.push_back(pick_cylinder(head, top));
            send_batch(cylinders);
            random_items += size;
         end
         drain_results();
         phase++;
      end

      repeat (40) @(posedge clock);
      if (schedule.pending() != 0) begin
         schedule.errors++;
         $display("%0t: %0d expected results never arrived", $time, schedule.pending());
      end
      $display("Sent %0d requests in %0d batches (%0d dropped on a full store) under %0d settings,",
               schedule.requests_taken, schedule.batches_closed, schedule.requests_dropped,
               schedule.settings_used);
      $display("and compared %0d service-order results field by field.",
               schedule.results_checked);
      if (schedule.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
